FILE: rtl/core/osm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_pkg: shared types and constants of the order statistic multiset
// Sizes of the sorted table and the action and status codes.
// ----------------------------------------------------------------------------
package osm_pkg;
	localparam int Capacity  = 1024;
	localparam int IdxBits   = 10;
	localparam int UsedBits  = 11;
	localparam int KeyBits   = 32;
	localparam int CntBits   = 20;
	localparam int TotBits   = 21;
	localparam int EntryBits = KeyBits + CntBits;

	typedef enum logic [2:0] {
		ACT_INSERT = 3'd0,
		ACT_REMOVE = 3'd1,
		ACT_RANK   = 3'd2,
		ACT_SELECT = 3'd3,
		ACT_PRED   = 3'd4,
		ACT_SUCC   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_NONE = 2'd1,
		ST_FULL = 2'd2
	} status_t;
endpackage

FILE: rtl/core/osm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// osm_ram: generic single-port RAM
// One write or one read per cycle; read data is registered.
// ----------------------------------------------------------------------------
module osm_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: rtl/core/order_statistic_multiset.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset: sorted multiset with rank and select
// Keys and copy counts live in one RAM, sorted by key.
// ----------------------------------------------------------------------------
// Each request is handled alone. The block scans the RAM from slot zero, one
// slot at a time (address, then registered read), up to the slot p where the
// scan stops. Inserting a new key or removing the last copy then shifts the
// tail, with a read and then a write for each moved slot. A result waits in an
// output register; no new request is taken until it is delivered.
module order_statistic_multiset (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// tdata: action [2:0], operand [34:3], zero [39:35]
	input  logic [39:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// tdata: answer [31:0], status [33:32], zero [39:34]
	output logic [39:0] m_tdata
);
	localparam int IB = osm_pkg::IdxBits;
	localparam int UB = osm_pkg::UsedBits;
	localparam int KB = osm_pkg::KeyBits;
	localparam int CB = osm_pkg::CntBits;
	localparam int TB = osm_pkg::TotBits;
	localparam int EB = osm_pkg::EntryBits;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ADDR  = 7'b0000010,
		S_CHK   = 7'b0000100,
		S_MRD   = 7'b0001000,
		S_MWR   = 7'b0010000,
		S_WRITE = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	logic [2:0]  act_q;
	logic signed [KB-1:0] op_q;
	logic [UB-1:0] idx_q, used_q, mv_q;
	logic [TB-1:0] tot_q;
	logic [TB+11:0] acc_q;
	logic signed [KB-1:0] prev_q, ans_q;
	logic [1:0]  st_q;
	logic [EB-1:0] ent_q;

	logic we;
	logic [IB-1:0] addr;
	logic [EB-1:0] wdata, rdata;

	osm_ram #(.Width(EB), .Depth(osm_pkg::Capacity)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	logic signed [KB-1:0] rkey;
	logic [CB-1:0] rcnt;
	logic [TB+11:0] acc_nx;
	logic in_range;
	logic hit;
	logic [UB-1:0] mv_dn;
	assign rkey     = rdata[EB-1:CB];
	assign rcnt     = rdata[CB-1:0];
	assign acc_nx   = acc_q + {12'd0, 1'b0, rcnt};
	assign in_range = idx_q < used_q;
	assign hit      = in_range && rkey == op_q;
	assign mv_dn    = mv_q - 1'b1;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = (state_q == S_OUT);
	assign m_tdata  = {6'd0, st_q, ans_q};

	// Insert moves slot mv-1 up to mv; remove moves slot mv down to mv-1.
	always_comb begin
		we    = 1'b0;
		addr  = idx_q[IB-1:0];
		wdata = ent_q;
		unique case (state_q)
			S_MRD: addr = (act_q == osm_pkg::ACT_INSERT) ? mv_dn[IB-1:0] : mv_q[IB-1:0];
			S_MWR: begin
				we = 1'b1;
				addr = (act_q == osm_pkg::ACT_INSERT) ? mv_q[IB-1:0] : mv_dn[IB-1:0];
				wdata = rdata;
			end
			S_WRITE: we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			tot_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (s_tvalid) begin
					act_q  <= s_tdata[2:0];
					op_q   <= s_tdata[34:3];
					idx_q  <= '0;
					acc_q  <= '0;
					st_q   <= osm_pkg::ST_OK;
					ans_q  <= '0;
					state_q <= S_ADDR;
				end
				S_ADDR: state_q <= S_CHK;
				S_CHK: begin
					// Scan step: rdata holds slot idx_q when idx_q is in range.
					priority if (act_q == osm_pkg::ACT_SELECT) begin
						if (op_q < 1 || op_q > $signed({11'd0, tot_q})) begin
							st_q <= osm_pkg::ST_NONE;
							state_q <= S_OUT;
						end else if (!in_range) begin
							st_q <= osm_pkg::ST_NONE;
							state_q <= S_OUT;
						end else if ($signed(acc_nx) >= $signed({{1{op_q[KB-1]}}, op_q})) begin
							ans_q <= rkey;
							state_q <= S_OUT;
						end else begin
							acc_q <= acc_nx;
							idx_q <= idx_q + 1'b1;
							state_q <= S_ADDR;
						end
					end else if (in_range && rkey < op_q) begin
						acc_q  <= acc_nx;
						prev_q <= rkey;
						idx_q  <= idx_q + 1'b1;
						state_q <= S_ADDR;
					end else begin
						unique case (act_q)
							osm_pkg::ACT_INSERT: begin
								if (tot_q == '1) begin
									st_q <= osm_pkg::ST_FULL;
									state_q <= S_OUT;
								end else if (hit) begin
									if (rcnt == '1) begin
										st_q <= osm_pkg::ST_FULL;
										state_q <= S_OUT;
									end else begin
										ent_q <= {rkey, rcnt + 1'b1};
										tot_q <= tot_q + 1'b1;
										state_q <= S_WRITE;
									end
								end else if (used_q == UB'(osm_pkg::Capacity)) begin
									st_q <= osm_pkg::ST_FULL;
									state_q <= S_OUT;
								end else begin
									// Shift the tail up from the top slot down to idx_q.
									ent_q <= {op_q, CB'(1)};
									tot_q <= tot_q + 1'b1;
									mv_q <= used_q;
									state_q <= (used_q == idx_q) ? S_WRITE : S_MRD;
									used_q <= used_q + 1'b1;
								end
							end
							osm_pkg::ACT_REMOVE: begin
								if (!hit) begin
									st_q <= osm_pkg::ST_NONE;
									state_q <= S_OUT;
								end else if (rcnt > 1) begin
									ent_q <= {rkey, rcnt - 1'b1};
									tot_q <= tot_q - 1'b1;
									state_q <= S_WRITE;
								end else begin
									tot_q <= tot_q - 1'b1;
									used_q <= used_q - 1'b1;
									mv_q <= idx_q + 1'b1;
									state_q <= (idx_q + 1'b1 < used_q) ? S_MRD : S_OUT;
								end
							end
							osm_pkg::ACT_RANK: begin
								ans_q <= acc_q[KB-1:0] + 1'b1;
								state_q <= S_OUT;
							end
							osm_pkg::ACT_PRED: begin
								if (idx_q == '0) st_q <= osm_pkg::ST_NONE;
								else ans_q <= prev_q;
								state_q <= S_OUT;
							end
							osm_pkg::ACT_SUCC: begin
								// On an exact hit, read the next slot; it is always larger.
								if (hit) begin
									idx_q <= idx_q + 1'b1;
									state_q <= S_ADDR;
								end else begin
									if (!in_range) st_q <= osm_pkg::ST_NONE;
									else ans_q <= rkey;
									state_q <= S_OUT;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_MRD: state_q <= S_MWR;
				S_MWR: begin
					if (act_q == osm_pkg::ACT_INSERT) begin
						if (mv_q - 1'b1 == idx_q) state_q <= S_WRITE;
						else begin
							mv_q <= mv_q - 1'b1;
							state_q <= S_MRD;
						end
					end else begin
						if (mv_q + 1'b1 > used_q) state_q <= S_OUT;
						else begin
							mv_q <= mv_q + 1'b1;
							state_q <= S_MRD;
						end
					end
				end
				S_WRITE: state_q <= S_OUT;
				S_OUT: if (m_tready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	sta_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid)) else $error("ready and valid together");
	sta_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= UB'(osm_pkg::Capacity)) else $error("table overflow");
	sta_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");
endmodule

FILE: sim/order_statistic_multiset_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// order_statistic_multiset_test: self-checking bench for the sorted multiset
// A short table of directed requests, then random requests mostly on a small key
// pool, then a fill of every slot to reach the full table. Responses are checked
// against a behavioral multiset in two queues, or a fixed answer in the table.
// ----------------------------------------------------------------------------
module order_statistic_multiset_test;
	localparam int          HalfPeriod = 6;
	localparam int          RandomReqs = 750;
	localparam longint      CycleLimit = 20000000;
	localparam int          DrainWait  = 4400;
	localparam logic [2:0]  ACT_SPARE6 = 3'd6;
	localparam logic [2:0]  ACT_SPARE7 = 3'd7;
	localparam int          CountMax   = 20'hFFFFF;
	localparam int          TotalMax   = 21'h1FFFFF;
	localparam int          KeyMin     = 32'sh80000000;
	localparam int          KeyMax     = 32'sh7FFFFFFF;

	typedef struct {
		logic [2:0]  act;
		int          opd;
		bit          fixed;
		int          ans;
		logic [1:0]  st;
	} req_row_t;

	typedef struct {
		int         ans;
		logic [1:0] st;
	} response_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;

	// Behavioral multiset: distinct keys ascending with their copy counts.
	int          set_keys[$];
	int          set_counts[$];
	int          set_total;
	response_t   pending_responses[$];
	req_row_t    directed[$];
	int          errors = 0;
	longint      cycles = 0;
	bit          busy_free = 1'b0;

	order_statistic_multiset dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #HalfPeriod clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic int lower_slot(int k);
		int p;
		p = 0;
		while (p < set_keys.size() && set_keys[p] < k)
			p++;
		return p;
	endfunction

	function automatic response_t apply_request(logic [2:0] act, int opd);
		response_t r;
		int p, acc, j;
		bit hit;
		r.ans = 0;
		r.st = osm_pkg::ST_OK;
		p = lower_slot(opd);
		hit = p < set_keys.size() && set_keys[p] == opd;
		case (act)
			osm_pkg::ACT_INSERT: begin
				if (set_total >= TotalMax) r.st = osm_pkg::ST_FULL;
				else if (hit) begin
					if (set_counts[p] >= CountMax) r.st = osm_pkg::ST_FULL;
					else begin
						set_counts[p]++;
						set_total++;
					end
				end else if (set_keys.size() >= osm_pkg::Capacity) r.st = osm_pkg::ST_FULL;
				else begin
					set_keys.insert(p, opd);
					set_counts.insert(p, 1);
					set_total++;
				end
			end
			osm_pkg::ACT_REMOVE: begin
				if (!hit) r.st = osm_pkg::ST_NONE;
				else begin
					if (set_counts[p] > 1) set_counts[p]--;
					else begin
						set_keys.delete(p);
						set_counts.delete(p);
					end
					set_total--;
				end
			end
			osm_pkg::ACT_RANK: begin
				acc = 0;
				for (j = 0; j < p; j++) acc += set_counts[j];
				r.ans = acc + 1;
			end
			osm_pkg::ACT_SELECT: begin
				if (opd < 1 || opd > set_total) r.st = osm_pkg::ST_NONE;
				else begin
					acc = 0;
					j = 0;
					while (j < set_keys.size()) begin
						acc += set_counts[j];
						if (acc >= opd) break;
						j++;
					end
					if (j < set_keys.size()) r.ans = set_keys[j];
					else r.st = osm_pkg::ST_NONE;
				end
			end
			osm_pkg::ACT_PRED: begin
				if (p == 0) r.st = osm_pkg::ST_NONE;
				else r.ans = set_keys[p - 1];
			end
			osm_pkg::ACT_SUCC: begin
				j = hit ? p + 1 : p;
				if (j >= set_keys.size()) r.st = osm_pkg::ST_NONE;
				else r.ans = set_keys[j];
			end
			default: ;
		endcase
		return r;
	endfunction

	// Presents one request, holding it until accepted, and records the expected
	// response at the accepting edge.
	task automatic send_request(req_row_t row);
		response_t r;
		while (!busy_free && $urandom_range(99) < 38) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {5'b0, row.opd, row.act};
		do @(posedge clk); while (!s_tready);
		r = apply_request(row.act, row.opd);
		if (row.fixed) begin
			r.ans = row.ans;
			r.st = row.st;
		end
		pending_responses.insert(pending_responses.size(), r);
		@(negedge clk);
	endtask

	function automatic req_row_t mk(logic [2:0] a, int o, bit f = 0, int an = 0,
			logic [1:0] s = osm_pkg::ST_OK);
		req_row_t row;
		row.act = a;
		row.opd = o;
		row.fixed = f;
		row.ans = an;
		row.st = s;
		return row;
	endfunction

	function automatic int pool_key();
		int sel;
		sel = $urandom_range(99);
		if (sel < 80) return $urandom_range(23) - 12;
		if (sel < 90) return $urandom();
		return sel[0] ? KeyMax : KeyMin;
	endfunction

	function automatic req_row_t random_request();
		int sel, opd;
		logic [2:0] act;
		sel = $urandom_range(99);
		if (sel < 30) act = osm_pkg::ACT_INSERT;
		else if (sel < 52)
			act = (set_keys.size() > 30) ? osm_pkg::ACT_REMOVE : osm_pkg::ACT_INSERT;
		else if (sel < 62) act = osm_pkg::ACT_REMOVE;
		else if (sel < 71) act = osm_pkg::ACT_RANK;
		else if (sel < 82) act = osm_pkg::ACT_SELECT;
		else if (sel < 89) act = osm_pkg::ACT_PRED;
		else if (sel < 96) act = osm_pkg::ACT_SUCC;
		else act = sel[0] ? ACT_SPARE6 : ACT_SPARE7;
		if (act == osm_pkg::ACT_SELECT && $urandom_range(9) != 0)
			opd = $urandom_range(set_total + 1);
		else
			opd = pool_key();
		return mk(act, opd);
	endfunction

	// Response side: random back-pressure outside the busy_free window, compare at the accepting edge.
	always @(negedge clk)
		m_tready <= busy_free || ($urandom_range(99) >= 38);

	always @(posedge clk) begin
		response_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_responses.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected response %h", m_tdata);
			end else begin
				want = pending_responses.pop_front();
				if (m_tdata[31:0] !== want.ans || m_tdata[33:32] !== want.st
						|| m_tdata[39:34] !== 6'b0) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: expected answer %0d status %0d, got %0d status %0d",
							want.ans, want.st, $signed(m_tdata[31:0]), m_tdata[33:32]);
				end
			end
		end
	end

	initial begin
		int i, k;
		set_total = 0;
		directed = '{
			mk(osm_pkg::ACT_RANK, 5, 1, 1, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_SELECT, 1, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_PRED, 0, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_SUCC, 0, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_REMOVE, 3, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_INSERT, KeyMin, 1, 0, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_INSERT, KeyMax, 1, 0, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_INSERT, 0, 1, 0, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_INSERT, 0, 1, 0, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_RANK, 0),
			mk(osm_pkg::ACT_RANK, KeyMax),
			mk(osm_pkg::ACT_SELECT, 1, 1, KeyMin, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_SELECT, 4, 1, KeyMax, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_SELECT, 5, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_SELECT, 0, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_SELECT, -1, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_PRED, KeyMin, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_SUCC, KeyMax, 1, 0, osm_pkg::ST_NONE),
			mk(osm_pkg::ACT_PRED, 0),
			mk(osm_pkg::ACT_SUCC, 0),
			mk(ACT_SPARE6, -1, 1, 0, osm_pkg::ST_OK),
			mk(ACT_SPARE7, 12345, 1, 0, osm_pkg::ST_OK),
			mk(osm_pkg::ACT_REMOVE, 0),
			mk(osm_pkg::ACT_REMOVE, KeyMax),
			mk(osm_pkg::ACT_SELECT, 3)
		};
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		foreach (directed[i]) send_request(directed[i]);
		s_tvalid <= 1'b0;
		// Hold the requests back until every response has been taken.
		while (pending_responses.size() != 0) @(negedge clk);
		for (i = 0; i < RandomReqs; i++) begin
			busy_free = (i >= 300 && i < 450);
			send_request(random_request());
		end
		busy_free = 1'b0;
		// Fill every slot, inserting ascending keys from 32'sh40000000 in steps of three.
		k = 32'sh40000000;
		while (set_keys.size() < osm_pkg::Capacity) begin
			send_request(mk(osm_pkg::ACT_INSERT, k));
			k += 3;
		end
		send_request(mk(osm_pkg::ACT_INSERT, 32'sh40000001, 1, 0, osm_pkg::ST_FULL));
		send_request(mk(osm_pkg::ACT_INSERT, 32'sh40000000));
		send_request(mk(osm_pkg::ACT_SELECT, set_total));
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0) @(negedge clk);
		repeat (DrainWait) @(negedge clk);
		if (errors == 0 && pending_responses.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/osm_pkg.sv
rtl/core/osm_ram.sv
rtl/core/order_statistic_multiset.sv
sim/order_statistic_multiset_test.sv
